>>> design/bbw_pkg.sv
// Package for the box blur window average block.
// Holds the request and result payload types, the queue entry type and fixed widths.
// No dependencies.
package bbw_pkg;

  localparam int PIXEL_W  = 16;
  localparam int AVG_W    = 16;
  localparam int CENTRE_W = 12;
  localparam int CFG_W    = 13;
  localparam int COUNT_W  = 13;
  localparam int SLOT_W   = 5;

  localparam logic [CFG_W-1:0] CFG_WIDTH_RESET = 13'd4096;

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel;
    logic               frame_start;
  } bbw_in_t;

  typedef struct packed {
    logic [AVG_W-1:0]    average;
    logic [CENTRE_W-1:0] centre_row;
    logic [CENTRE_W-1:0] centre_col;
  } bbw_out_t;

  typedef struct packed {
    logic                emit;
    logic                first_col;
    logic                full_col;
    logic [CENTRE_W-1:0] centre_row;
    logic [CENTRE_W-1:0] centre_col;
  } bbw_ctrl_t;

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel;
    logic [COUNT_W-1:0] col;
    logic [SLOT_W-1:0]  slot;
    bbw_ctrl_t          ctrl;
  } bbw_item_t;

endpackage

>>> design/box_blur_window_average.sv
// Top level of the box blur window average block: front, request queue and back.
// Depends on bbw_pkg, bbw_front, bbw_queue and bbw_back.
//
//   Channel  Handshake             Payload
//   in       in_valid / in_ready   in_data  (pixel, frame_start)
//   out      out_valid / out_ready out_data (average, centre_row, centre_col)
//   cfg      cfg_we                cfg_wdata (image width)
//
// One request is accepted per cycle while in_ready is high.
// The rate is set by the row store banks, each read and written once per cycle.
// Reset is synchronous; the row stores are not cleared and need no clearing pass.
// A stalled output fills a small result FIFO, then the request queue, then
// in_ready drops.
module box_blur_window_average #(
  parameter int MAX_WIDTH  = 4096,
  parameter int WINDOW     = 15,
  parameter int PIXEL_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [bbw_pkg::CFG_W-1:0]  cfg_wdata,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  bbw_pkg::bbw_in_t           in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output bbw_pkg::bbw_out_t          out_data
);
  import bbw_pkg::*;

  logic      q_push, q_full, q_pop, q_empty;
  bbw_item_t q_push_item, q_pop_item;

  bbw_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .WINDOW    (WINDOW)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .q_push    (q_push),
    .q_item    (q_push_item),
    .q_full    (q_full)
  );

  bbw_queue #(
    .DEPTH (4)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_push_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (q_pop_item),
    .empty     (q_empty)
  );

  bbw_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .WINDOW     (WINDOW),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_item    (q_pop_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> design/bbw_queue.sv
// Short FIFO of classified requests between the front and back parts.
// Depends on bbw_pkg for the entry type.
module bbw_queue #(
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  bbw_pkg::bbw_item_t  push_item,
  output logic                full,
  input  logic                pop,
  output bbw_pkg::bbw_item_t  pop_item,
  output logic                empty
);
  import bbw_pkg::*;

  localparam int AW = $clog2(DEPTH);

  bbw_item_t    entry_r [DEPTH];
  logic [AW:0]  wr_ptr_r, wr_ptr_nxt;
  logic [AW:0]  rd_ptr_r, rd_ptr_nxt;

  assign empty    = (wr_ptr_r == rd_ptr_r);
  assign full     = (wr_ptr_r[AW] != rd_ptr_r[AW]) && (wr_ptr_r[AW-1:0] == rd_ptr_r[AW-1:0]);
  assign pop_item = entry_r[rd_ptr_r[AW-1:0]];

  assign wr_ptr_nxt = wr_ptr_r + (AW+1)'(1);
  assign rd_ptr_nxt = rd_ptr_r + (AW+1)'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr_r <= wr_ptr_nxt;
      end
      if (pop && !empty) begin
        rd_ptr_r <= rd_ptr_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      entry_r[wr_ptr_r[AW-1:0]] <= push_item;
    end
  end

endmodule

>>> design/bbw_front.sv
// Front part: accepts pixel requests, tracks row, column and row store slot,
// and classifies each request for the back part. Holds the image width register.
// Depends on bbw_pkg.
module bbw_front #(
  parameter int MAX_WIDTH = 4096,
  parameter int WINDOW    = 15
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [bbw_pkg::CFG_W-1:0]   cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  bbw_pkg::bbw_in_t            in_data,
  output logic                        q_push,
  output bbw_pkg::bbw_item_t          q_item,
  input  logic                        q_full
);
  import bbw_pkg::*;

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int HALF = WINDOW / 2;

  logic [CFG_W-1:0]   width_r;
  logic [CW-1:0]      col_r, col_nxt, col_base;
  logic [COUNT_W-1:0] row_r, row_nxt, row_base, row_inc;
  logic [SLOT_W-1:0]  slot_r, slot_nxt, slot_base;
  logic [WW-1:0]      width_eff, col_inc;
  logic               accept, row_end;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign q_push   = accept;

  assign col_base  = in_data.frame_start ? '0 : col_r;
  assign row_base  = in_data.frame_start ? '0 : row_r;
  assign slot_base = in_data.frame_start ? '0 : slot_r;

  always_comb begin
    if (width_r == '0) begin
      width_eff = WW'(1);
    end else if ((CFG_W+1)'(width_r) > (CFG_W+1)'(MAX_WIDTH)) begin
      width_eff = WW'(MAX_WIDTH);
    end else begin
      width_eff = WW'(width_r);
    end
  end

  assign col_inc = WW'(col_base) + WW'(1);
  assign row_end = (col_inc >= width_eff);
  assign row_inc = row_base + COUNT_W'(1);

  always_comb begin
    col_nxt  = CW'(col_inc);
    row_nxt  = row_base;
    slot_nxt = slot_base;
    if (row_end) begin
      col_nxt = '0;
      row_nxt = row_inc;
      if (row_inc == '0 || slot_base == SLOT_W'(WINDOW - 2)) begin
        slot_nxt = '0;
      end else begin
        slot_nxt = slot_base + SLOT_W'(1);
      end
    end
  end

  always_comb begin
    q_item.pixel           = in_data.pixel;
    q_item.col             = COUNT_W'(col_base);
    q_item.slot            = slot_base;
    q_item.ctrl.emit       = (row_base >= COUNT_W'(WINDOW - 1)) &&
                             (COUNT_W'(col_base) >= COUNT_W'(WINDOW - 1));
    q_item.ctrl.first_col  = (col_base == '0);
    q_item.ctrl.full_col   = (COUNT_W'(col_base) >= COUNT_W'(WINDOW));
    q_item.ctrl.centre_row = CENTRE_W'(row_base - COUNT_W'(HALF));
    q_item.ctrl.centre_col = CENTRE_W'(COUNT_W'(col_base) - COUNT_W'(HALF));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= CFG_WIDTH_RESET;
      col_r   <= '0;
      row_r   <= '0;
      slot_r  <= '0;
    end else begin
      if (cfg_we) begin
        width_r <= cfg_wdata;
      end
      if (accept) begin
        col_r  <= col_nxt;
        row_r  <= row_nxt;
        slot_r <= slot_nxt;
      end
    end
  end

endmodule

>>> design/bbw_back.sv
// Back part: row store banks, column sum tree, running window sum, reciprocal
// divide by the window area and the result FIFO. Depends on bbw_pkg.
module bbw_back #(
  parameter int MAX_WIDTH  = 4096,
  parameter int WINDOW     = 15,
  parameter int PIXEL_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  bbw_pkg::bbw_item_t  q_item,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output bbw_pkg::bbw_out_t   out_data
);
  import bbw_pkg::*;

  localparam int CW        = $clog2(MAX_WIDTH);
  localparam int PB        = PIXEL_BITS;
  localparam int ROWS_KEPT = WINDOW - 1;
  localparam int AREA      = WINDOW * WINDOW;
  localparam int CSW       = PB + $clog2(WINDOW);
  localparam int WSW       = PB + $clog2(AREA);
  localparam int SHIFT     = WSW + $clog2(AREA);
  localparam int MW        = WSW + 2;
  localparam int PW        = WSW + MW;
  localparam int NG        = (WINDOW + 3) / 4;
  localparam int PTW       = PB + 2;
  localparam longint unsigned RECIP_L =
    ((64'd1 << SHIFT) + 64'(AREA) - 64'd1) / 64'(AREA);
  localparam logic [MW-1:0]  RECIP     = MW'(RECIP_L);
  localparam logic [WSW-1:0] HALF_AREA = WSW'(AREA / 2);
  localparam int OUT_DEPTH = 8;
  localparam int OAW       = $clog2(OUT_DEPTH);
  localparam int OCW       = $clog2(OUT_DEPTH + 1);

  logic [OCW-1:0] occ_r, occ_nxt;
  logic           pop_emit, out_take, fifo_push;

  logic            s0_v_r, s1_v_r, s2_v_r, s3_v_r, s4_v_r, s5_v_r;
  bbw_ctrl_t       s0_ctrl_r, s1_ctrl_r, s2_ctrl_r, s3_ctrl_r, s4_ctrl_r, s5_ctrl_r;
  logic [CW-1:0]   s0_addr_r;
  logic [PB-1:0]   s0_pix_r, s1_pix_r;
  logic [SLOT_W-1:0] s0_slot_r;

  logic [PB-1:0]   bank_rd [ROWS_KEPT];
  logic [PB-1:0]   vals [NG*4];
  logic [PTW-1:0]  part_sum [NG];
  logic [PTW-1:0]  part_r [NG];
  logic [CSW-1:0]  cs_sum, cs_r;
  logic [CSW-1:0]  hist_r [WINDOW];
  logic [WSW-1:0]  ws_r, ws_nxt, ws_rounded;
  logic [PW-1:0]   prod_r, prod_nxt;

  bbw_out_t        fifo_r [OUT_DEPTH];
  bbw_out_t        fifo_in;
  logic [OAW:0]    wr_ptr_r, rd_ptr_r;

  assign pop_emit = q_item.ctrl.emit;
  assign q_pop    = !q_empty && (!pop_emit || occ_r < OCW'(OUT_DEPTH));
  assign out_take = out_valid && out_ready;

  always_comb begin
    occ_nxt = occ_r;
    if (q_pop && pop_emit && !out_take) begin
      occ_nxt = occ_r + OCW'(1);
    end else if (!(q_pop && pop_emit) && out_take) begin
      occ_nxt = occ_r - OCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r  <= '0;
      s0_v_r <= 1'b0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
    end else begin
      occ_r  <= occ_nxt;
      s0_v_r <= q_pop;
      s1_v_r <= s0_v_r;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
      s5_v_r <= s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s0_addr_r <= q_item.col[CW-1:0];
    s0_pix_r  <= PB'(q_item.pixel);
    s0_slot_r <= q_item.slot;
    s0_ctrl_r <= q_item.ctrl;
    s1_pix_r  <= s0_pix_r;
    s1_ctrl_r <= s0_ctrl_r;
    s2_ctrl_r <= s1_ctrl_r;
    s3_ctrl_r <= s2_ctrl_r;
    s4_ctrl_r <= s3_ctrl_r;
    s5_ctrl_r <= s4_ctrl_r;
  end

  for (genvar k = 0; k < ROWS_KEPT; k++) begin : g_bank
    logic [PB-1:0] mem [MAX_WIDTH];
    logic [PB-1:0] rd_q;

    always_ff @(posedge clk) begin
      if (s0_v_r) begin
        rd_q <= mem[s0_addr_r];
        if (s0_slot_r == SLOT_W'(k)) begin
          mem[s0_addr_r] <= s0_pix_r;
        end
      end
    end

    assign bank_rd[k] = rd_q;
  end

  always_comb begin
    for (int i = 0; i < NG*4; i++) begin
      vals[i] = '0;
    end
    for (int i = 0; i < ROWS_KEPT; i++) begin
      vals[i] = bank_rd[i];
    end
    vals[WINDOW-1] = s1_pix_r;
    for (int g = 0; g < NG; g++) begin
      part_sum[g] = PTW'(vals[g*4]) + PTW'(vals[g*4+1]) +
                    PTW'(vals[g*4+2]) + PTW'(vals[g*4+3]);
    end
  end

  always_comb begin
    cs_sum = '0;
    for (int g = 0; g < NG; g++) begin
      cs_sum = cs_sum + CSW'(part_r[g]);
    end
  end

  always_ff @(posedge clk) begin
    part_r <= part_sum;
    cs_r   <= cs_sum;
  end

  always_comb begin
    if (s3_ctrl_r.first_col) begin
      ws_nxt = WSW'(cs_r);
    end else if (s3_ctrl_r.full_col) begin
      ws_nxt = ws_r + WSW'(cs_r) - WSW'(hist_r[WINDOW-1]);
    end else begin
      ws_nxt = ws_r + WSW'(cs_r);
    end
  end

  always_ff @(posedge clk) begin
    if (s3_v_r) begin
      ws_r      <= ws_nxt;
      hist_r[0] <= cs_r;
      for (int i = 1; i < WINDOW; i++) begin
        hist_r[i] <= hist_r[i-1];
      end
    end
  end

  assign ws_rounded = ws_r + HALF_AREA;
  assign prod_nxt   = PW'(ws_rounded) * PW'(RECIP);

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  assign fifo_push          = s5_v_r && s5_ctrl_r.emit;
  assign fifo_in.average    = AVG_W'(prod_r[PW-1:SHIFT]);
  assign fifo_in.centre_row = s5_ctrl_r.centre_row;
  assign fifo_in.centre_col = s5_ctrl_r.centre_col;

  assign out_valid = (wr_ptr_r != rd_ptr_r);
  assign out_data  = fifo_r[rd_ptr_r[OAW-1:0]];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      if (fifo_push) begin
        wr_ptr_r <= wr_ptr_r + (OAW+1)'(1);
      end
      if (out_take) begin
        rd_ptr_r <= rd_ptr_r + (OAW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fifo_push) begin
      fifo_r[wr_ptr_r[OAW-1:0]] <= fifo_in;
    end
  end

endmodule
